[hdl/pss_pkg.sv]
// pixel scan sequencer package: beat types, function codes, phase encoding
// used by every module of the sequencer; no dependencies
`default_nettype none

package pss_pkg;

    // widths fixed by the beat formats
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int PIX_W       = 16;
    localparam int FIF_W       = 16;

    // function codes of an input beat
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_START   = 2'd1;
    localparam logic [1:0] FUNC_TRIGGER = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_PER_FILE = 8'd1;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] PIXEL_COUNT_RST     = 16'd100;
    localparam logic [CFG_DATA_W-1:0] FRAMES_PER_FILE_RST = 16'd128;

    // external phase codes
    localparam logic [3:0] CODE_IDLE       = 4'd0;
    localparam logic [3:0] CODE_START      = 4'd1;
    localparam logic [3:0] CODE_WAIT_TRG   = 4'd2;
    localparam logic [3:0] CODE_WAIT_CAP   = 4'd3;
    localparam logic [3:0] CODE_CAP_START  = 4'd4;
    localparam logic [3:0] CODE_PROV_START = 4'd5;
    localparam logic [3:0] CODE_WAIT_HI    = 4'd6;
    localparam logic [3:0] CODE_WAIT_LO    = 4'd7;
    localparam logic [3:0] CODE_DECIDE     = 4'd8;
    localparam logic [3:0] CODE_END        = 4'd9;

    // one-hot phase machine
    typedef enum logic [9:0] {
        PH_IDLE       = 10'b00_0000_0001,
        PH_START      = 10'b00_0000_0010,
        PH_WAIT_TRG   = 10'b00_0000_0100,
        PH_WAIT_CAP   = 10'b00_0000_1000,
        PH_CAP_START  = 10'b00_0001_0000,
        PH_PROV_START = 10'b00_0010_0000,
        PH_WAIT_HI    = 10'b00_0100_0000,
        PH_WAIT_LO    = 10'b00_1000_0000,
        PH_DECIDE     = 10'b01_0000_0000,
        PH_END        = 10'b10_0000_0000
    } phase_t;

    // input beat
    typedef struct packed {
        logic [1:0] func;
        logic       capture_received;
        logic       provider_pass;
    } pss_in_t;

    // result beat
    typedef struct packed {
        logic             start_accepted;
        logic             capture_start;
        logic             provider_start;
        logic             scan_done;
        logic             busy_res;
        logic [PIX_W-1:0] pixel_index;
        logic [3:0]       phase_code;
    } pss_out_t;

    // staged beat handed from the input register to the core
    typedef struct packed {
        logic    valid;
        pss_in_t data;
    } pss_stage_t;

    // map the one-hot phase to its external code
    function automatic logic [3:0] phase_code_f(input phase_t ph);
        logic [3:0] code;
        code = CODE_IDLE;
        unique case (ph)
            PH_IDLE:       code = CODE_IDLE;
            PH_START:      code = CODE_START;
            PH_WAIT_TRG:   code = CODE_WAIT_TRG;
            PH_WAIT_CAP:   code = CODE_WAIT_CAP;
            PH_CAP_START:  code = CODE_CAP_START;
            PH_PROV_START: code = CODE_PROV_START;
            PH_WAIT_HI:    code = CODE_WAIT_HI;
            PH_WAIT_LO:    code = CODE_WAIT_LO;
            PH_DECIDE:     code = CODE_DECIDE;
            PH_END:        code = CODE_END;
            default:       code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[hdl/pss_in_stage.sv]
// pixel scan sequencer input register: holds one accepted beat until the core takes it
// depends on pss_pkg
`default_nettype none

module pss_in_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire pss_pkg::pss_in_t    in_data,
    input  wire logic                advance,
    output pss_pkg::pss_stage_t      stage
);
    import pss_pkg::*;

    logic    valid_reg;
    pss_in_t data_reg;

    // hold while a staged beat cannot move on
    assign in_stall = valid_reg && !advance;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

[hdl/pss_core.sv]
// pixel scan sequencer core: config registers, phase machine, counters, result logic
// depends on pss_pkg
`default_nettype none

module pss_core #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [pss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pss_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire pss_pkg::pss_stage_t                 stage,
    input  wire logic                                advance,
    output pss_pkg::pss_out_t                        result
);
    import pss_pkg::*;

    localparam int EXT_W = (COUNTER_WIDTH > CFG_DATA_W) ? COUNTER_WIDTH : CFG_DATA_W;

    logic [CFG_DATA_W-1:0]    pixel_count_reg;
    logic [CFG_DATA_W-1:0]    frames_per_file_reg;
    phase_t                   phase_reg, phase_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg, cnt_next;
    logic [FIF_W-1:0]         fif_reg, fif_next;
    logic                     trig_reg, trig_next;

    logic [EXT_W-1:0]         last_ext;
    logic [COUNTER_WIDTH-1:0] last_pixel;
    logic [FIF_W:0]           fif_inc;
    logic                     acc, cap_start, prov_start, done;

    // last pixel index wrapped to the counter width
    assign last_ext   = EXT_W'(pixel_count_reg) - EXT_W'(1);
    assign last_pixel = last_ext[COUNTER_WIDTH-1:0];
    assign fif_inc    = {1'b0, fif_reg} + {{FIF_W{1'b0}}, 1'b1};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg     <= PIXEL_COUNT_RST;
            frames_per_file_reg <= FRAMES_PER_FILE_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_PIXEL_COUNT)
            begin
                pixel_count_reg <= cfg_data;
            end
            else if (cfg_index == CFG_FRAMES_PER_FILE)
            begin
                frames_per_file_reg <= cfg_data;
            end
        end
    end

    // next state and pulses for the staged beat
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        fif_next   = fif_reg;
        trig_next  = trig_reg;
        acc        = 1'b0;
        cap_start  = 1'b0;
        prov_start = 1'b0;
        done       = 1'b0;
        unique case (stage.data.func)
            FUNC_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_START;
                    acc        = 1'b1;
                end
            end
            FUNC_TRIGGER:
            begin
                trig_next = 1'b1;
            end
            FUNC_TICK:
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        cnt_next   = '0;
                        fif_next   = '0;
                        phase_next = PH_WAIT_TRG;
                    end
                    PH_WAIT_TRG:
                    begin
                        if (trig_reg)
                        begin
                            trig_next  = 1'b0;
                            phase_next = (fif_reg == '0) ? PH_WAIT_CAP : PH_PROV_START;
                        end
                    end
                    PH_WAIT_CAP:
                    begin
                        if ((cnt_reg == '0) || stage.data.capture_received)
                        begin
                            phase_next = PH_CAP_START;
                        end
                    end
                    PH_CAP_START:
                    begin
                        cap_start  = (fif_reg == '0);
                        phase_next = PH_PROV_START;
                    end
                    PH_PROV_START:
                    begin
                        prov_start = 1'b1;
                        phase_next = PH_WAIT_HI;
                    end
                    PH_WAIT_HI:
                    begin
                        if (stage.data.provider_pass)
                        begin
                            phase_next = PH_WAIT_LO;
                        end
                    end
                    PH_WAIT_LO:
                    begin
                        if (!stage.data.provider_pass)
                        begin
                            phase_next = PH_DECIDE;
                        end
                    end
                    PH_DECIDE:
                    begin
                        if (cnt_reg == last_pixel)
                        begin
                            phase_next = PH_END;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_WAIT_TRG;
                            cnt_next   = cnt_reg + COUNTER_WIDTH'(1);
                            // wrap the group position at the file boundary
                            if (fif_inc >= {1'b0, frames_per_file_reg})
                            begin
                                fif_next = '0;
                            end
                            else
                            begin
                                fif_next = fif_inc[FIF_W-1:0];
                            end
                        end
                    end
                    PH_END:
                    begin
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // state registers advance with each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            fif_reg   <= '0;
            trig_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            fif_reg   <= fif_next;
            trig_reg  <= trig_next;
        end
    end

    // result beat
    assign result.start_accepted = acc;
    assign result.capture_start  = cap_start;
    assign result.provider_start = prov_start;
    assign result.scan_done      = done;
    assign result.busy_res       = (phase_next != PH_IDLE);
    assign result.pixel_index    = PIX_W'(cnt_next);
    assign result.phase_code     = phase_code_f(phase_next);

    // a beat is only processed when one is staged
    a_staged: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> stage.valid)
        else $error("processed a beat with nothing staged");

    // at most one command pulse per beat
    a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> ($countones({acc, cap_start, prov_start, done}) <= 1))
        else $error("more than one pulse in one beat");

    // a finished scan lands in the end phase
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && done) |=> (phase_reg == PH_END))
        else $error("scan_done without end phase");

    // provider start is followed by the wait for pass high
    a_prov_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && prov_start) |=> (phase_reg == PH_WAIT_HI))
        else $error("provider_start without wait for pass");

    // state does not move without a processed beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(phase_reg) && $stable(cnt_reg) && $stable(trig_reg)))
        else $error("state changed without a beat");

endmodule

`default_nettype wire

[hdl/pss_out_stage.sv]
// pixel scan sequencer result register: holds one result beat for the receiver
// depends on pss_pkg
`default_nettype none

module pss_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 stage_valid,
    input  wire pss_pkg::pss_out_t    result,
    output logic                      advance,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pss_pkg::pss_out_t         out_data
);
    import pss_pkg::*;

    logic     valid_reg;
    pss_out_t data_reg;
    logic     room;

    // register is free when empty or when its beat leaves now
    assign room    = !valid_reg || !out_stall;
    assign advance = stage_valid && room;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= stage_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[hdl/pixel_scan_sequencer.sv]
// pixel scan sequencer top level: input register, core, result register
// depends on pss_pkg, pss_in_stage, pss_core, pss_out_stage
//
// Usage:
//   Input beats carry func (tick, start request, trigger) plus the capture
//   complete and provider pass flags. Every input beat yields exactly one
//   result beat with the command pulses, busy flag, pixel index and phase.
//   Configuration writes (pixel_count at index 0, frames_per_file at index 1)
//   go over the cfg channel, always ready, and should only be made while idle.
//   Path: a beat accepted into the input register passes the combinational
//   core and is captured in the result register. Throughput: one beat per
//   cycle while the receiver does not stall; each beat is a single phase
//   step with a counter increment and compare. Reset: phase idle, counters
//   and latched trigger cleared, pixel_count 100, frames_per_file 128, both channels empty.
//   When the receiver stalls, the result register holds its beat, the staged
//   beat waits behind it, and in_stall rises once the input register is full.
`default_nettype none

module pixel_scan_sequencer #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire pss_pkg::pss_in_t                 in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output pss_pkg::pss_out_t                     out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pss_pkg::*;

    pss_stage_t stage;
    pss_out_t   result;
    logic       advance;

    assign cfg_ready = 1'b1;

    // input register
    pss_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .advance  (advance),
        .stage    (stage)
    );

    // phase machine and counters
    pss_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stage     (stage),
        .advance   (advance),
        .result    (result)
    );

    // result register
    pss_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage.valid),
        .result      (result),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
